// ----- design/pixel_histogram_inverse_percent_unit_defines.svh -----
// assertion macros for the pixel histogram unit and its checker
// no dependencies; each macro takes a label, clock, active-low reset and two expressions
`ifndef PIXEL_HISTOGRAM_INVERSE_PERCENT_UNIT_DEFINES_SVH
`define PIXEL_HISTOGRAM_INVERSE_PERCENT_UNIT_DEFINES_SVH

// same-cycle implication
`define PHIP_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("phip assertion failed");

// next-cycle implication
`define PHIP_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("phip assertion failed");

`endif

// ----- design/phip_pkg.sv -----
// shared types and constants for the pixel histogram unit
// no dependencies
package phip_pkg;

    localparam int PIX_BITS  = 8;
    localparam int PCT_BITS  = 7;
    localparam logic [PCT_BITS-1:0] PCT_SCALE = 7'd100;

    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_QUERY  = 1'b1;

    typedef enum logic [1:0] {
        DIV_IDLE,
        DIV_RUN,
        DIV_DONE
    } div_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

// ----- design/pixel_histogram_inverse_percent_unit.sv -----
// top level of the pixel histogram unit: bin memory, peak tracking, query result
// depends on phip_pkg, phip_ram, phip_div
//
//  channel | ports                                        | dir | transfer
//  --------+----------------------------------------------+-----+---------------------
//  input   | s_valid s_ready s_kind s_value               | in  | s_valid && s_ready
//  result  | m_valid m_ready m_bin_count m_peak_count     | out | m_valid && m_ready
//          | m_inverse_percent m_empty_res                |     |
//
// samples stream back to back, one per cycle, while no query is in flight; the bin
// memory is read at accept and written back next cycle, a forwarding register covers
// repeats; a query holds s_ready low through the bin read and divider load, the seven
// quotient steps and the hand-over, and longer while m_ready is low
// reset is synchronous, active low; the bins read as zero at once through one
// valid flip-flop per bin, so there is no clearing pass
// a finished result waits in the output register while samples keep flowing
module pixel_histogram_inverse_percent_unit #(
    parameter int COUNT_BITS = 21,
    parameter int NUM_BINS   = 256
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic                               s_kind,
    input  logic [phip_pkg::PIX_BITS-1:0]      s_value,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [COUNT_BITS-1:0]              m_bin_count,
    output logic [COUNT_BITS-1:0]              m_peak_count,
    output logic [phip_pkg::PCT_BITS-1:0]      m_inverse_percent,
    output logic                               m_empty_res
);

    import phip_pkg::*;

    localparam int IDX_BITS = $clog2(NUM_BINS);
    localparam logic [PIX_BITS:0]     BINS_LIMIT = (PIX_BITS + 1)'(NUM_BINS);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX  = {COUNT_BITS{1'b1}};

    // input transfer and bin read
    logic                  accept;
    logic                  in_range;
    logic [COUNT_BITS-1:0] ram_rd_data;

    // stage 1: item whose bin data has just come back
    logic                  s1_valid_reg;
    logic                  s1_kind_reg;
    logic                  s1_inr_reg;
    logic [IDX_BITS-1:0]   s1_idx_reg;

    // last write, for read-after-write on the same bin
    logic                  fwd_valid_reg;
    logic [IDX_BITS-1:0]   fwd_idx_reg;
    logic [COUNT_BITS-1:0] fwd_data_reg;

    logic [NUM_BINS-1:0]   bin_vld_reg;
    logic [COUNT_BITS-1:0] peak_reg, peak_next;

    logic                  fwd_hit;
    logic [COUNT_BITS-1:0] stored_count;
    logic [COUNT_BITS-1:0] cur_count;
    logic [COUNT_BITS-1:0] inc_count;
    logic                  sample_fire;
    logic                  query_fire;
    logic [COUNT_BITS-1:0] q_diff;

    // query held while the divider works
    logic [COUNT_BITS-1:0] q_count_reg;
    logic [COUNT_BITS-1:0] q_peak_reg;
    logic                  q_empty_reg;

    div_stat_t             div_stat;
    logic [PCT_BITS-1:0]   div_quo;
    logic                  div_take;

    // result register
    logic                  m_valid_reg;
    logic [COUNT_BITS-1:0] m_bin_count_reg;
    logic [COUNT_BITS-1:0] m_peak_count_reg;
    logic [PCT_BITS-1:0]   m_pct_reg;
    logic                  m_empty_reg;

    // one query in flight at a time
    assign s_ready  = !(s1_valid_reg && s1_kind_reg == KIND_QUERY) && !div_stat.busy;
    assign accept   = s_valid && s_ready;
    assign in_range = {1'b0, s_value} < BINS_LIMIT;

    phip_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (NUM_BINS)
    ) u_bins (
        .aclk    (aclk),
        .wr_en   (sample_fire),
        .wr_addr (s1_idx_reg),
        .wr_data (inc_count),
        .rd_en   (accept),
        .rd_addr (s_value[IDX_BITS-1:0]),
        .rd_data (ram_rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_kind_reg <= s_kind;
            s1_inr_reg  <= in_range;
            s1_idx_reg  <= s_value[IDX_BITS-1:0];
        end
    end

    // bin count: forwarded write, else memory if the bin was ever written, else zero
    assign fwd_hit      = fwd_valid_reg && fwd_idx_reg == s1_idx_reg;
    assign stored_count = fwd_hit ? fwd_data_reg :
                          ((s1_inr_reg && bin_vld_reg[s1_idx_reg]) ? ram_rd_data : '0);
    assign cur_count    = s1_inr_reg ? stored_count : '0;
    // saturate at the counter maximum
    assign inc_count    = (cur_count == COUNT_MAX) ? cur_count : cur_count + 1'b1;

    assign sample_fire  = s1_valid_reg && s1_kind_reg == KIND_SAMPLE && s1_inr_reg;
    assign query_fire   = s1_valid_reg && s1_kind_reg == KIND_QUERY;
    assign q_diff       = (peak_reg >= cur_count) ? peak_reg - cur_count : '0;

    assign peak_next    = (sample_fire && inc_count > peak_reg) ? inc_count : peak_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bin_vld_reg   <= '0;
            fwd_valid_reg <= 1'b0;
            peak_reg      <= '0;
        end else begin
            peak_reg <= peak_next;
            if (sample_fire) begin
                bin_vld_reg[s1_idx_reg] <= 1'b1;
                fwd_valid_reg           <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (sample_fire) begin
            fwd_idx_reg  <= s1_idx_reg;
            fwd_data_reg <= inc_count;
        end
    end

    always_ff @(posedge aclk) begin
        if (query_fire) begin
            q_count_reg <= cur_count;
            q_peak_reg  <= peak_reg;
            q_empty_reg <= peak_reg == '0;
        end
    end

    phip_div #(
        .COUNT_BITS (COUNT_BITS)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (query_fire),
        .take     (div_take),
        .diff     (q_diff),
        .divisor  (peak_reg),
        .stat     (div_stat),
        .quotient (div_quo)
    );

    // hand over when the result register is empty or being emptied
    assign div_take = div_stat.done && (!m_valid_reg || m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (div_take) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (div_take) begin
            m_bin_count_reg  <= q_count_reg;
            m_peak_count_reg <= q_peak_reg;
            // empty histogram reports zero instead of the divide-by-zero quotient
            m_pct_reg        <= q_empty_reg ? '0 : div_quo;
            m_empty_reg      <= q_empty_reg;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_bin_count       = m_bin_count_reg;
    assign m_peak_count      = m_peak_count_reg;
    assign m_inverse_percent = m_pct_reg;
    assign m_empty_res       = m_empty_reg;

endmodule

// ----- design/phip_ram.sv -----
// generic single-write, single-read synchronous ram with registered read
// no dependencies
module phip_ram #(
    parameter int WIDTH = 21,
    parameter int DEPTH = 256
) (
    input  logic                           aclk,
    input  logic                           wr_en,
    input  logic [$clog2(DEPTH)-1:0]       wr_addr,
    input  logic [WIDTH-1:0]               wr_data,
    input  logic                           rd_en,
    input  logic [$clog2(DEPTH)-1:0]       rd_addr,
    output logic [WIDTH-1:0]               rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule

// ----- design/phip_div.sv -----
// iterative unit for 100*diff/divisor, one quotient bit per cycle
// depends on phip_pkg
module phip_div #(
    parameter int COUNT_BITS = 21
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               start,
    input  logic                               take,
    input  logic [COUNT_BITS-1:0]              diff,
    input  logic [COUNT_BITS-1:0]              divisor,
    output phip_pkg::div_stat_t                stat,
    output logic [phip_pkg::PCT_BITS-1:0]      quotient
);

    import phip_pkg::*;

    localparam int DW = COUNT_BITS + PCT_BITS;
    localparam int SW = $clog2(PCT_BITS);

    div_state_t state_reg, state_next;

    logic [DW-1:0]       rem_reg, rem_next;
    logic [DW-1:0]       dsr_reg, dsr_next;
    logic [PCT_BITS-1:0] quo_reg, quo_next;
    logic [SW-1:0]       step_reg, step_next;
    logic                ge;

    assign ge = rem_reg >= dsr_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            DIV_IDLE: begin
                if (start) state_next = DIV_RUN;
            end
            DIV_RUN: begin
                if (step_reg == '0) state_next = DIV_DONE;
            end
            DIV_DONE: begin
                if (take) state_next = DIV_IDLE;
            end
            default: state_next = DIV_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        stat.busy = 1'b0;
        stat.done = 1'b0;
        case (state_reg)
            DIV_IDLE: begin
                stat.busy = 1'b0;
            end
            DIV_RUN: begin
                stat.busy = 1'b1;
            end
            DIV_DONE: begin
                stat.busy = 1'b1;
                stat.done = 1'b1;
            end
            default: begin
                stat.busy = 1'b0;
            end
        endcase
    end

    // datapath: restoring steps against divisor shifted down one bit per cycle
    always_comb begin
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        quo_next  = quo_reg;
        step_next = step_reg;
        if (state_reg == DIV_IDLE && start) begin
            rem_next  = DW'(diff) * DW'(PCT_SCALE);
            dsr_next  = DW'(divisor) << (PCT_BITS - 1);
            quo_next  = '0;
            step_next = SW'(PCT_BITS - 1);
        end else if (state_reg == DIV_RUN) begin
            if (ge) rem_next = rem_reg - dsr_reg;
            dsr_next  = dsr_reg >> 1;
            quo_next  = {quo_reg[PCT_BITS-2:0], ge};
            step_next = step_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= DIV_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg  <= rem_next;
        dsr_reg  <= dsr_next;
        quo_reg  <= quo_next;
        step_reg <= step_next;
    end

    assign quotient = quo_reg;

endmodule

// ----- design/phip_chk.sv -----
// port-level checker for the pixel histogram unit, bound to the top level
// depends on phip_pkg and the assertion macro header
`include "pixel_histogram_inverse_percent_unit_defines.svh"

module phip_chk #(
    parameter int COUNT_BITS = 21
) (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               m_valid,
    input logic                               m_ready,
    input logic [COUNT_BITS-1:0]              m_bin_count,
    input logic [COUNT_BITS-1:0]              m_peak_count,
    input logic [phip_pkg::PCT_BITS-1:0]      m_inverse_percent,
    input logic                               m_empty_res
);

    import phip_pkg::*;

    logic [2*COUNT_BITS+PCT_BITS:0] res_word;
    logic                           res_zero;
    logic                           peak_ok;

    assign res_word = {m_bin_count, m_peak_count, m_inverse_percent, m_empty_res};
    assign res_zero = m_peak_count == '0 && m_bin_count == '0 && m_inverse_percent == '0;
    assign peak_ok  = m_bin_count <= m_peak_count && m_peak_count != '0;

    // stalled result holds
    `PHIP_ASSERT_NEXT(a_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(res_word))

    // percentage never above full scale
    `PHIP_ASSERT_NOW(a_pct_range, aclk, aresetn, m_valid, m_inverse_percent <= PCT_SCALE)

    // empty histogram reports all zero
    `PHIP_ASSERT_NOW(a_empty, aclk, aresetn, m_valid && m_empty_res, res_zero)

    // a bin never exceeds the peak, and the peak is nonzero once not empty
    `PHIP_ASSERT_NOW(a_peak, aclk, aresetn, m_valid && !m_empty_res, peak_ok)

endmodule

bind pixel_histogram_inverse_percent_unit phip_chk #(.COUNT_BITS(COUNT_BITS)) u_phip_chk (.*);
